@@ hdl/cla_pkg.sv @@
// Shared definitions for the console line assembler: result codes, character
// constants, command-word tables and the controller/datapath handshake structs.
// No dependencies.
package cla_pkg;

   localparam int LINE_DEPTH_DEF = 256;

   // Input selector values.
   localparam logic [1:0] MODE_RX      = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;

   // Result codes reported with every item.
   typedef enum logic [2:0] {
      EV_STORED   = 3'd0,
      EV_EMPTY    = 3'd1,
      EV_ERASE    = 3'd2,
      EV_OVERFLOW = 3'd3,
      EV_BUSY     = 3'd4,
      EV_DONE     = 3'd5,
      EV_RELEASED = 3'd6,
      EV_READ     = 3'd7
   } ev_code_type;

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_DEL = 8'h7F;

   localparam logic [3:0] LONG_WORD_LEN  = 4'd10;
   localparam logic [3:0] SHORT_WORD_LEN = 4'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic decode;
      logic write_lf;
      logic cmp_step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic line_end;
      logic cmp_needed;
      logic cmp_last;
      logic out_free;
   } status_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   // Characters of AT+RESTORE (long_word set) or AT+RST.
   function automatic logic [7:0] word_char(input logic long_word, input logic [3:0] k);
      logic [7:0] r;
      r = 8'h00;
      case (k)
         4'd0: r = "A";
         4'd1: r = "T";
         4'd2: r = "+";
         4'd3: r = "R";
         4'd4: r = long_word ? "E" : "S";
         4'd5: r = long_word ? "S" : "T";
         4'd6: r = "T";
         4'd7: r = "O";
         4'd8: r = "R";
         4'd9: r = "E";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/cla_ctrl.sv @@
// Sequencing state machine of the console line assembler.
// Depends on cla_pkg for the command and status structs.
module cla_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  cla_pkg::status_type status,
   output cla_pkg::cmd_type    cmd
);
   import cla_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_LF     = 5'b00100,
      S_CMP    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = status.line_end ? S_LF : S_DONE;
         end
         S_LF: begin
            cmd.write_lf = 1'b1;
            state_in     = status.cmp_needed ? S_CMP : S_DONE;
         end
         S_CMP: begin
            cmd.cmp_step = 1'b1;
            if (status.cmp_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/cla_dpath.sv @@
// Datapath of the console line assembler: line memory, fill and line state,
// command-word compare and the result register. Depends on cla_pkg.
module cla_dpath #(
   parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_tuser,
   input  logic [23:0]         req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2:0]          rsp_tuser,
   output logic [31:0]         rsp_tdata,
   input  cla_pkg::cmd_type    cmd,
   output cla_pkg::status_type status
);
   import cla_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);

   logic [7:0]      line_mem [LINE_DEPTH];

   // Captured item.
   logic [1:0]      mode_ff;
   logic [7:0]      rx_ff;
   logic            txf_ff;
   logic [7:0]      ridx_ff;

   // Line state.
   logic [AW-1:0]   fill_ff, fill_in;
   logic            pending_ff, pending_in;
   logic [8:0]      held_ff, held_in;
   logic            reboot_ff, reboot_in;
   ev_code_type     ev_ff, ev_in;

   // Compare state.
   logic            long_ff, match_ff, cmp_need_ff;
   logic [3:0]      cnt_ff;
   logic            rd_ok_ff;
   logic [7:0]      rd_q_ff;

   // Result register.
   logic            rsp_valid_ff;
   logic [2:0]      rsp_user_ff;
   logic [31:0]     rsp_data_ff;

   logic            is_term, is_erase, fill_zero, overflow, rx_mode;
   logic [AW:0]     fill_plus2;
   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_wa, mem_ra;
   logic [7:0]      mem_wd;
   logic [3:0]      cmp_len;
   logic            idx_in_range;

   assign rx_mode      = (mode_ff == MODE_RX);
   assign is_term      = (rx_ff == CH_CR) || (rx_ff == CH_LF);
   assign is_erase     = (rx_ff == CH_BS) || (rx_ff == CH_DEL);
   assign fill_zero    = (fill_ff == '0);
   assign overflow     = (32'(fill_ff) >= LINE_DEPTH - 2);
   assign fill_plus2   = {1'b0, fill_ff} + (AW + 1)'(2);
   assign cmp_len      = long_ff ? LONG_WORD_LEN : SHORT_WORD_LEN;
   assign idx_in_range = (32'(ridx_ff) < LINE_DEPTH);

   assign status.line_end   = rx_mode && !pending_ff && is_term && !fill_zero;
   assign status.cmp_needed = cmp_need_ff;
   assign status.cmp_last   = (cnt_ff == cmp_len);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // Event and line-state update.
   always_comb begin
      fill_in    = fill_ff;
      pending_in = pending_ff;
      held_in    = held_ff;
      reboot_in  = reboot_ff;
      ev_in      = ev_ff;
      mem_we     = 1'b0;
      mem_wa     = fill_ff;
      mem_wd     = rx_ff;
      mem_re     = 1'b0;
      mem_ra     = AW'(ridx_ff);
      if (cmd.decode) begin
         if (rx_mode) begin
            if (pending_ff) begin
               ev_in = EV_BUSY;
            end else if (is_term) begin
               if (fill_zero) begin
                  ev_in = EV_EMPTY;
               end else begin
                  ev_in  = EV_DONE;
                  mem_we = 1'b1;
                  mem_wd = CH_CR;
               end
            end else if (is_erase) begin
               ev_in = EV_ERASE;
               if (!fill_zero) begin
                  fill_in = fill_ff - AW'(1);
               end
            end else if (overflow) begin
               ev_in   = EV_OVERFLOW;
               fill_in = '0;
            end else begin
               ev_in   = EV_STORED;
               mem_we  = 1'b1;
               fill_in = fill_ff + AW'(1);
            end
         end else if (mode_ff == MODE_RELEASE) begin
            ev_in      = EV_RELEASED;
            pending_in = 1'b0;
         end else begin
            ev_in  = EV_READ;
            mem_re = idx_in_range;
         end
      end
      if (cmd.write_lf) begin
         mem_we     = 1'b1;
         mem_wa     = fill_ff + AW'(1);
         mem_wd     = CH_LF;
         held_in    = 9'(fill_plus2);
         fill_in    = '0;
         pending_in = 1'b1;
      end
      if (cmd.cmp_step && (cnt_ff != cmp_len)) begin
         mem_re = 1'b1;
         mem_ra = AW'(cnt_ff);
      end
      if (cmd.load_out && ev_ff == EV_DONE) begin
         reboot_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q_ff <= line_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser;
         rx_ff   <= req_tdata[7:0];
         txf_ff  <= req_tdata[8];
         ridx_ff <= req_tdata[16:9];
      end
      if (cmd.decode) begin
         ev_ff       <= ev_in;
         rd_ok_ff    <= idx_in_range;
         long_ff     <= (32'(fill_ff) == 10);
         cmp_need_ff <= (32'(fill_ff) == 10) || (32'(fill_ff) == 6);
         match_ff    <= 1'b1;
         cnt_ff      <= '0;
      end
      if (cmd.write_lf && !cmp_need_ff) begin
         match_ff <= 1'b0;
      end
      if (cmd.cmp_step) begin
         if (cnt_ff != cmp_len) begin
            cnt_ff <= cnt_ff + 4'd1;
         end
         if (cnt_ff != 4'd0 && to_upper(rd_q_ff) != word_char(long_ff, cnt_ff - 4'd1)) begin
            match_ff <= 1'b0;
         end
      end
      if (cmd.load_out) begin
         rsp_user_ff <= ev_ff;
         rsp_data_ff <= {4'd0,
                         ((ev_ff == EV_READ && rd_ok_ff) ? rd_q_ff : 8'h00),
                         reboot_in,
                         held_ff,
                         pending_ff,
                         (rx_mode ? rx_ff : 8'h00),
                         (rx_mode && txf_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pending_ff   <= 1'b0;
         held_ff      <= '0;
         reboot_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
         reboot_ff  <= reboot_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/console_line_assembler.sv @@
// Top level of the console line assembler: joins the controller and datapath.
// Depends on cla_pkg, cla_ctrl and cla_dpath.
//
// Usage: each item on the req_ stream carries a mode in req_tuser (received
// console byte, release of the pending line, or read of one buffer byte) and
// the byte, transmitter-free flag and read position in req_tdata. Every item
// yields exactly one item on the rsp_ stream: the echo decision, the event
// code in rsp_tuser, the line flags and length, and the byte read.
// Sequence: an ordinary byte, an erase, a release or a read goes from decode
// straight to the result step; a terminator that closes a non-empty line
// while none is pending also writes the line feed and, when the line has the
// length of a reboot command (6 or 10), compares it, reading the stored bytes
// back one per cycle through the single read port of the line memory. A new
// item is accepted only after the previous result is in the output register.
// Reset (synchronous, active high) clears the fill position, the pending
// flag, the latched length and reboot flag and the output valid; the line
// memory is not cleared. When the receiver stalls, the finished result holds
// in the output register while the next item is already accepted and worked
// on; that item then waits in its final step until the register frees up.
module console_line_assembler #(
   parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // mode
   input  logic [23:0] req_tdata,   // rx_byte, tx_free, read_index, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // event_res
   // echo_valid, echo_byte, line_ready, line_length, reboots_slave, read_byte, zero fill
   output logic [31:0] rsp_tdata
);
   import cla_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller steps through decode, terminator write and command
   // compare; the datapath does all storage and arithmetic.
   cla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cla_dpath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
